[hdl/lzbd_pkg.sv]
// Shared types and constants of the LZ4 block decoder.
package lzbd_pkg;

  localparam int LEN_W  = 24;
  localparam int CFG_AW = 3;

  localparam logic [LEN_W-1:0] CAP_RESET   = 24'd65536;
  localparam logic [3:0]       NIBBLE_EXT  = 4'h0F;
  localparam logic [7:0]       EXT_CONT    = 8'd255;
  localparam logic [3:0]       EXT_START   = 4'd15;
  localparam logic [2:0]       MATCH_MIN   = 3'd4;

  localparam logic REG_OUT_CAPACITY = 1'b0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_CAP      = 3'd2;
  localparam logic [2:0] ST_ZERO_OFF = 3'd3;
  localparam logic [2:0] ST_FAR_OFF  = 3'd4;
  localparam logic [2:0] ST_BUSY     = 3'd5;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LITERAL,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT,
    PH_COPY
  } phase_t;

  typedef struct packed {
    logic             wr;
    logic             from_ram;
    logic [7:0]       lit;
    logic             pend;
    logic             done;
    logic [2:0]       status;
    logic [LEN_W-1:0] total_len;
    logic [LEN_W-1:0] wr_ptr;
  } step_t;

endpackage

[hdl/lzbd_ram.sv]
// Generic synchronous RAM with one write port and one registered read port.
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lzbd_cfg.sv]
// Configuration register file with APB-style access.
module lzbd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lzbd_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [lzbd_pkg::LEN_W-1:0]      out_capacity
);

  logic                          reg_idx;
  logic                          wr_en;
  logic [lzbd_pkg::LEN_W-1:0]    cap_r;
  logic [lzbd_pkg::LEN_W-1:0]    cap_nxt;

  assign pready  = 1'b1;
  assign reg_idx = paddr[lzbd_pkg::CFG_AW-1];
  assign wr_en   = psel && penable && pwrite && pready &&
                   (reg_idx == lzbd_pkg::REG_OUT_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en) begin
      cap_nxt = pwdata[lzbd_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lzbd_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == lzbd_pkg::REG_OUT_CAPACITY) begin
      prdata = {{(32 - lzbd_pkg::LEN_W){1'b0}}, cap_r};
    end
  end

  assign out_capacity = cap_r;

endmodule

[hdl/lzbd_ctrl.sv]
// Sequence parser: token, length, offset, copy state; one request a cycle on accept.
module lzbd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         mode,
  input  logic [7:0]                   in_byte,
  input  logic                         is_last,
  input  logic [lzbd_pkg::LEN_W-1:0]   out_capacity,
  output logic [lzbd_pkg::LEN_W-1:0]   rd_ptr,
  output lzbd_pkg::step_t              step
);

  localparam int LW = lzbd_pkg::LEN_W;

  lzbd_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0] lit_left_r, lit_left_nxt;
  logic [LW-1:0] match_left_r, match_left_nxt;
  logic [15:0]   offset_r, offset_nxt;
  logic [3:0]    nibble_r, nibble_nxt;
  logic [LW-1:0] produced_r, produced_nxt;
  logic          end_seen_r, end_seen_nxt;

  logic [2:0]    st;
  logic          done;
  logic          wr;
  logic          from_ram;
  logic [7:0]    lit;
  logic          lit_go;
  logic          match_go;
  logic [LW-1:0] lit_n;
  logic [LW:0]   match_n;
  logic [LW:0]   acc;
  logic [15:0]   off;
  logic [LW:0]   fit_n;
  logic [LW+1:0] fit_sum;
  logic          fit_ok;
  logic          pend;

  always_comb begin
    phase_nxt      = phase_r;
    lit_left_nxt   = lit_left_r;
    match_left_nxt = match_left_r;
    offset_nxt     = offset_r;
    nibble_nxt     = nibble_r;
    produced_nxt   = produced_r;
    end_seen_nxt   = end_seen_r;
    st             = lzbd_pkg::ST_OK;
    done           = 1'b0;
    wr             = 1'b0;
    from_ram       = 1'b0;
    lit            = '0;
    lit_go         = 1'b0;
    match_go       = 1'b0;
    lit_n          = '0;
    match_n        = '0;
    acc            = '0;
    off            = '0;
    fit_n          = '0;
    fit_sum        = '0;
    fit_ok         = 1'b0;
    pend           = 1'b0;

    if (mode) begin
      if (phase_r == lzbd_pkg::PH_COPY && match_left_r != '0) begin
        wr             = 1'b1;
        from_ram       = 1'b1;
        produced_nxt   = produced_r + 1'b1;
        match_left_nxt = match_left_r - 1'b1;
        if (match_left_r == {{(LW-1){1'b0}}, 1'b1}) begin
          if (end_seen_r) begin
            done = 1'b1;
          end else begin
            phase_nxt = lzbd_pkg::PH_TOKEN;
          end
        end
      end
    end else begin
      unique case (phase_r)
        lzbd_pkg::PH_TOKEN: begin
          nibble_nxt = in_byte[3:0];
          if (in_byte[7:4] == lzbd_pkg::NIBBLE_EXT) begin
            lit_left_nxt = {{(LW-4){1'b0}}, lzbd_pkg::EXT_START};
            phase_nxt    = lzbd_pkg::PH_LIT_EXT;
            if (is_last) begin
              st = lzbd_pkg::ST_TRUNC;
            end
          end else begin
            lit_go = 1'b1;
            lit_n  = {{(LW-4){1'b0}}, in_byte[7:4]};
          end
        end
        lzbd_pkg::PH_LIT_EXT: begin
          acc = {1'b0, lit_left_r} + {{(LW-7){1'b0}}, in_byte};
          if (acc > {1'b0, out_capacity}) begin
            st = lzbd_pkg::ST_CAP;
          end else if (in_byte == lzbd_pkg::EXT_CONT) begin
            lit_left_nxt = acc[LW-1:0];
            if (is_last) begin
              st = lzbd_pkg::ST_TRUNC;
            end
          end else begin
            lit_go = 1'b1;
            lit_n  = acc[LW-1:0];
          end
        end
        lzbd_pkg::PH_LITERAL: begin
          if (is_last && lit_left_r > {{(LW-1){1'b0}}, 1'b1}) begin
            st = lzbd_pkg::ST_TRUNC;
          end else begin
            wr           = 1'b1;
            lit          = in_byte;
            produced_nxt = produced_r + 1'b1;
            lit_left_nxt = lit_left_r - 1'b1;
            if (lit_left_r == {{(LW-1){1'b0}}, 1'b1}) begin
              if (is_last) begin
                done = 1'b1;
              end else begin
                phase_nxt = lzbd_pkg::PH_OFF_LO;
              end
            end
          end
        end
        lzbd_pkg::PH_OFF_LO: begin
          offset_nxt = {8'd0, in_byte};
          phase_nxt  = lzbd_pkg::PH_OFF_HI;
          if (is_last) begin
            st = lzbd_pkg::ST_TRUNC;
          end
        end
        lzbd_pkg::PH_OFF_HI: begin
          off = {in_byte, offset_r[7:0]};
          if (off == '0) begin
            st = lzbd_pkg::ST_ZERO_OFF;
          end else if ({{(LW-16){1'b0}}, off} > produced_r) begin
            st = lzbd_pkg::ST_FAR_OFF;
          end else begin
            offset_nxt = off;
            if (nibble_r == lzbd_pkg::NIBBLE_EXT) begin
              match_left_nxt = {{(LW-4){1'b0}}, lzbd_pkg::EXT_START};
              phase_nxt      = lzbd_pkg::PH_MATCH_EXT;
              if (is_last) begin
                st = lzbd_pkg::ST_TRUNC;
              end
            end else begin
              match_go = 1'b1;
              match_n  = {{(LW-3){1'b0}}, nibble_r} +
                         {{(LW-2){1'b0}}, lzbd_pkg::MATCH_MIN};
            end
          end
        end
        lzbd_pkg::PH_MATCH_EXT: begin
          acc = {1'b0, match_left_r} + {{(LW-7){1'b0}}, in_byte};
          if (acc > {1'b0, out_capacity}) begin
            st = lzbd_pkg::ST_CAP;
          end else if (in_byte == lzbd_pkg::EXT_CONT) begin
            match_left_nxt = acc[LW-1:0];
            if (is_last) begin
              st = lzbd_pkg::ST_TRUNC;
            end
          end else begin
            match_go = 1'b1;
            match_n  = acc + {{(LW-2){1'b0}}, lzbd_pkg::MATCH_MIN};
          end
        end
        default: begin
          st = lzbd_pkg::ST_BUSY;
        end
      endcase

      fit_n   = match_go ? match_n : {1'b0, lit_n};
      fit_sum = {2'b00, produced_r} + {1'b0, fit_n};
      fit_ok  = fit_sum <= {2'b00, out_capacity};

      if (lit_go) begin
        if (is_last && lit_n != '0) begin
          st = lzbd_pkg::ST_TRUNC;
        end else if (!fit_ok) begin
          st = lzbd_pkg::ST_CAP;
        end else if (lit_n == '0) begin
          if (is_last) begin
            done = 1'b1;
          end else begin
            phase_nxt = lzbd_pkg::PH_OFF_LO;
          end
        end else begin
          lit_left_nxt = lit_n;
          phase_nxt    = lzbd_pkg::PH_LITERAL;
        end
      end

      if (match_go) begin
        if (!fit_ok) begin
          st = lzbd_pkg::ST_CAP;
        end else begin
          match_left_nxt = match_n[LW-1:0];
          end_seen_nxt   = is_last;
          phase_nxt      = lzbd_pkg::PH_COPY;
        end
      end
    end

    pend = (st == lzbd_pkg::ST_OK) && !done &&
           (phase_nxt == lzbd_pkg::PH_COPY) && (match_left_nxt != '0);

    step.wr        = wr;
    step.from_ram  = from_ram;
    step.lit       = lit;
    step.pend      = pend;
    step.done      = done;
    step.status    = st;
    step.total_len = produced_nxt;
    step.wr_ptr    = produced_r;

    if (st != lzbd_pkg::ST_OK || done) begin
      phase_nxt      = lzbd_pkg::PH_TOKEN;
      lit_left_nxt   = '0;
      match_left_nxt = '0;
      offset_nxt     = '0;
      nibble_nxt     = '0;
      produced_nxt   = '0;
      end_seen_nxt   = 1'b0;
    end
  end

  assign rd_ptr = produced_r - {{(LW-16){1'b0}}, offset_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lzbd_pkg::PH_TOKEN;
      lit_left_r   <= '0;
      match_left_r <= '0;
      offset_r     <= '0;
      nibble_r     <= '0;
      produced_r   <= '0;
      end_seen_r   <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      lit_left_r   <= lit_left_nxt;
      match_left_r <= match_left_nxt;
      offset_r     <= offset_nxt;
      nibble_r     <= nibble_nxt;
      produced_r   <= produced_nxt;
      end_seen_r   <= end_seen_nxt;
    end
  end

endmodule

[hdl/lz4_block_decoder_unit.sv]
// LZ4 block decoder top level: parser, history RAM, read stage and output register.
//
// One request a cycle, compressed byte or copy tick, sustained as long as the result
// side takes one result a cycle; each request gives exactly one result, held first in
// the read stage and then in the output register. A copy tick reads the history RAM
// (registered read) at acceptance and the byte is written back from the read stage,
// with a bypass when the read address is the one being written, so offsets of one or
// more repeat at full rate. The history RAM is not cleared after reset; offsets never
// reach unwritten entries. The read stage plus the output register hold two results,
// and in_tready follows out_tready combinationally once both are full.
module lz4_block_decoder_unit #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tuser,   // [0] mode
  input  logic                          in_tlast,   // is_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [7:0] out_byte, [8] copy_pending,
                                                    // [11:9] status, [35:12] total_len
  output logic                          out_tuser,  // [0] out_valid
  output logic                          out_tlast,  // done_res
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lzbd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = lzbd_pkg::LEN_W;

  logic [LW-1:0]   out_capacity;
  logic            accept;
  logic [LW-1:0]   rd_ptr;
  lzbd_pkg::step_t step;

  logic            s1_valid_r, s1_valid_nxt;
  lzbd_pkg::step_t s1_step_r;
  logic            s1_fwd_r;
  logic [7:0]      s1_fwd_data_r;
  logic            s1_advance;
  logic [7:0]      s1_byte;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_q;

  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r;
  logic            out_user_r;
  logic            out_last_r;

  lzbd_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .out_capacity (out_capacity)
  );

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign accept     = in_tvalid && in_tready;

  lzbd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .mode         (in_tuser),
    .in_byte      (in_tdata),
    .is_last      (in_tlast),
    .out_capacity (out_capacity),
    .rd_ptr       (rd_ptr),
    .step         (step)
  );

  assign ram_raddr = rd_ptr[AW-1:0];
  assign ram_waddr = s1_step_r.wr_ptr[AW-1:0];
  assign ram_we    = s1_valid_r && s1_advance && s1_step_r.wr;

  lzbd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_byte),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    s1_byte = '0;
    if (s1_step_r.wr) begin
      if (s1_step_r.from_ram) begin
        s1_byte = s1_fwd_r ? s1_fwd_data_r : ram_q;
      end else begin
        s1_byte = s1_step_r.lit;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_valid_r && s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step_r     <= step;
      s1_fwd_r      <= ram_we && (ram_waddr == ram_raddr);
      s1_fwd_data_r <= s1_byte;
    end
    if (s1_valid_r && s1_advance) begin
      out_data_r <= {{(40 - 12 - LW){1'b0}}, s1_step_r.total_len, s1_step_r.status,
                     s1_step_r.pend, s1_byte};
      out_user_r <= s1_step_r.wr;
      out_last_r <= s1_step_r.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not taken while read stage empty");

  a_hold_read_data: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance && s1_step_r.from_ram && !s1_fwd_r) |=>
      (s1_valid_r && $stable(ram_q)))
    else $error("history read data lost during stall");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[11:9] == lzbd_pkg::ST_OK && !out_tdata[8]))
    else $error("done reported with error or pending copy");

  a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11:9] != lzbd_pkg::ST_OK) |-> (!out_tuser && !out_tlast))
    else $error("error result carries a byte or done");

endmodule
